// ----- src/twc_pkg.sv -----
// twc_pkg: shared constants and types for the tight word counter
// no dependencies; imported by twc_mod_add and tight_word_counter
`timescale 1ns / 1ps

package twc_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam int unsigned SYM_IN_W = 4;
  localparam int unsigned LEN_IN_W = 11;
  localparam int unsigned SUM_W = COUNT_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(100003);
  localparam logic [SUM_W-1:0] COUNT_MOD_X1 = SUM_W'(100003);
  localparam logic [SUM_W-1:0] COUNT_MOD_X2 = SUM_W'(200006);

  localparam int unsigned DEF_MAX_SYMBOLS = 16;
  localparam int unsigned DEF_LEN_LIMIT = 1024;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

// ----- src/tight_word_counter.sv -----
// tight_word_counter: counts words whose neighboring symbols differ by at most one
// depends on twc_pkg and twc_mod_add
`timescale 1ns / 1ps

// channel | signals                                       | direction
// input   | in_valid_i, in_ready_o, largest_symbol_i,     | into block
//         | word_length_i                                 |
// output  | out_valid_o, out_ready_i, word_count_o        | out of block
//
// one item at a time; with k the saturated largest symbol and n the saturated
// length, the row of k+1 entries is set to one, updated n-1 times and then
// summed; zero length gives a count of one directly. the single modular adder and
// the one-read, one-write count row handle one row entry per cycle.
// reset clears the sequencer and output valid; the row is written before use.
// a waiting result holds in the output register while the next item is taken.

module tight_word_counter #(
  parameter int unsigned MAX_SYMBOLS = twc_pkg::DEF_MAX_SYMBOLS,
  parameter int unsigned LEN_LIMIT   = twc_pkg::DEF_LEN_LIMIT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [twc_pkg::SYM_IN_W-1:0]    largest_symbol_i,
  input  logic [twc_pkg::LEN_IN_W-1:0]    word_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output twc_pkg::count_t                 word_count_o
);
  import twc_pkg::*;

  localparam int unsigned SYM_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned LEN_W = $clog2(LEN_LIMIT + 1);
  localparam int unsigned ST_W = 3;

  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_INIT = 3'd1;
  localparam logic [ST_W-1:0] ST_RD0  = 3'd2;
  localparam logic [ST_W-1:0] ST_LOAD = 3'd3;
  localparam logic [ST_W-1:0] ST_STEP = 3'd4;
  localparam logic [ST_W-1:0] ST_SUM0 = 3'd5;
  localparam logic [ST_W-1:0] ST_SUMS = 3'd6;
  localparam logic [ST_W-1:0] ST_EMIT = 3'd7;

  logic [ST_W-1:0]  state_q, state_d;
  logic [SYM_W-1:0] k_q, k_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic [LEN_W-1:0] len_rem_q, len_rem_d;
  count_t           left_q, left_d;
  count_t           same_q, same_d;
  count_t           total_q, total_d;
  count_t           rd_data_q;
  logic             out_valid_q, out_valid_d;
  count_t           word_count_q, word_count_d;

  logic [SYM_W-1:0] k_sat;
  logic [LEN_W-1:0] n_sat;
  logic [SYM_W:0]   sym_plus2;
  logic             sym_last;
  count_t           right_val;

  count_t           op_a, op_b, op_c, unit_sum;

  logic             mem_we, mem_re;
  logic [SYM_W-1:0] mem_wa, mem_ra;
  count_t           mem_wd;
  count_t           count_row [MAX_SYMBOLS];

  assign k_sat = (32'(largest_symbol_i) > (MAX_SYMBOLS - 1)) ? SYM_W'(MAX_SYMBOLS - 1)
                                                              : SYM_W'(largest_symbol_i);
  assign n_sat = (32'(word_length_i) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT)
                                                  : LEN_W'(word_length_i);

  assign sym_plus2 = {1'b0, sym_q} + (SYM_W + 1)'(2);
  assign sym_last  = (sym_q == k_q);
  assign right_val = sym_last ? '0 : rd_data_q;

  // shared modular adder: row update in the step state, running total otherwise
  always_comb begin
    if (state_q == ST_STEP) begin
      op_a = left_q;
      op_b = same_q;
      op_c = right_val;
    end else begin
      op_a = total_q;
      op_b = rd_data_q;
      op_c = '0;
    end
  end

  twc_mod_add u_mod_add (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .op_c_i (op_c),
    .sum_o  (unit_sum)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    sym_d        = sym_q;
    len_rem_d    = len_rem_q;
    left_d       = left_q;
    same_d       = same_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q;
    word_count_d = word_count_q;
    mem_we       = 1'b0;
    mem_wa       = sym_q;
    mem_wd       = unit_sum;
    mem_re       = 1'b0;
    mem_ra       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          k_d   = k_sat;
          sym_d = '0;
          if (n_sat == '0) begin
            total_d = count_t'(1);
            state_d = ST_EMIT;
          end else begin
            len_rem_d = n_sat - LEN_W'(1);
            state_d   = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = count_t'(1);
        sym_d  = sym_q + SYM_W'(1);
        if (sym_last) begin
          state_d = (len_rem_q == '0) ? ST_SUM0 : ST_RD0;
        end
      end
      ST_RD0: begin
        mem_re  = 1'b1;
        sym_d   = '0;
        left_d  = '0;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        same_d  = rd_data_q;
        mem_re  = (k_q != '0);
        mem_ra  = SYM_W'(1);
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // rd_data_q holds the old value of the right neighbour
        mem_we = 1'b1;
        left_d = same_q;
        same_d = right_val;
        mem_re = (sym_plus2 <= {1'b0, k_q});
        mem_ra = sym_plus2[SYM_W-1:0];
        sym_d  = sym_q + SYM_W'(1);
        if (sym_last) begin
          len_rem_d = len_rem_q - LEN_W'(1);
          state_d   = (len_rem_q == LEN_W'(1)) ? ST_SUM0 : ST_RD0;
        end
      end
      ST_SUM0: begin
        mem_re  = 1'b1;
        sym_d   = '0;
        total_d = '0;
        state_d = ST_SUMS;
      end
      ST_SUMS: begin
        total_d = unit_sum;
        mem_re  = !sym_last;
        mem_ra  = sym_q + SYM_W'(1);
        sym_d   = sym_q + SYM_W'(1);
        if (sym_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          word_count_d = total_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      sym_q       <= '0;
      len_rem_q   <= '0;
      left_q      <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      sym_q       <= sym_d;
      len_rem_q   <= len_rem_d;
      left_q      <= left_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    same_q       <= same_d;
    word_count_q <= word_count_d;
  end

  // count row: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_row[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= count_row[mem_ra];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_count_o = word_count_q;

  a_total_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q < COUNT_MOD)
    else $error("running total out of modular range");

  a_sym_within_k : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT || state_q == ST_STEP || state_q == ST_SUMS) |-> sym_q <= k_q)
    else $error("symbol index beyond largest symbol");

  a_zero_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && word_length_i == '0) |=>
      (state_q == ST_EMIT && total_q == count_t'(1)))
    else $error("zero length item did not yield a count of one");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_o || out_ready_i)) |=>
      (out_valid_o && word_count_o == $past(total_q)))
    else $error("finished count not moved to output register");

endmodule

// ----- src/twc_mod_add.sv -----
// twc_mod_add: three-operand adder with reduction modulo 100003
// each operand must already be below the modulus; uses twc_pkg
`timescale 1ns / 1ps

module twc_mod_add (
  input  twc_pkg::count_t op_a_i,
  input  twc_pkg::count_t op_b_i,
  input  twc_pkg::count_t op_c_i,
  output twc_pkg::count_t sum_o
);
  import twc_pkg::*;

  logic [SUM_W-1:0] raw_sum;
  logic [SUM_W-1:0] red_sum;

  assign raw_sum = SUM_W'(op_a_i) + SUM_W'(op_b_i) + SUM_W'(op_c_i);

  // sum stays below three times the modulus, so at most two subtractions
  always_comb begin
    if (raw_sum >= COUNT_MOD_X2) begin
      red_sum = raw_sum - COUNT_MOD_X2;
    end else if (raw_sum >= COUNT_MOD_X1) begin
      red_sum = raw_sum - COUNT_MOD_X1;
    end else begin
      red_sum = raw_sum;
    end
  end

  assign sum_o = red_sum[COUNT_W-1:0];

endmodule
